// File: rtl/i2cms_pkg.sv
// Shared types and constants for the I2C master bit sequencer.
// Used by the front, the command queue and the back sequencer; no dependencies.
package i2cms_pkg;

  // Command codes as carried on the input channel
  typedef enum logic [2:0] {
    KIND_START    = 3'd0,
    KIND_STOP     = 3'd1,
    KIND_WRITE    = 3'd2,
    KIND_READ     = 3'd3,
    KIND_SEND_ACK = 3'd4,
    KIND_RECV_ACK = 3'd5
  } kind_t;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;
  localparam logic [15:0] HALF_PERIOD_RESET = 16'd500;

  // Decoded command as it sits in the queue
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;  // tx byte for write, slave bits for read
    logic       ack;   // driven ack for send, slave ack for receive
  } cmd_t;

  // Handshake group between front and queue, and queue and back
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_beat_t;

endpackage

// File: rtl/i2cms_cmd_if.sv
// Command channel: one I2C command per beat.
// Depends on nothing; fields follow the command item layout.
interface i2cms_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] tx_byte;
  logic       ack_bit;
  logic [7:0] slave_bits;
  logic       slave_ack;

  modport source(output valid, kind, tx_byte, ack_bit, slave_bits, slave_ack,
                 input ready);
  modport sink(input valid, kind, tx_byte, ack_bit, slave_bits, slave_ack,
               output ready);
endinterface

// File: rtl/i2cms_phase_if.sv
// Phase channel: one SCL/SDA pin phase per beat.
// Depends on nothing.
interface i2cms_phase_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       sampled;
  logic [7:0] rx_data;
  logic       rx_ack;
  logic       last;

  modport source(output valid, scl_level, sda_level, sampled, rx_data, rx_ack, last,
                 input ready);
  modport sink(input valid, scl_level, sda_level, sampled, rx_data, rx_ack, last,
               output ready);
endinterface

// File: rtl/i2cms_cfg_if.sv
// Configuration write channel carrying the half-period register value.
// Depends on nothing.
interface i2cms_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

// File: rtl/i2cms_front.sv
// Front end: accepts command beats, drops undefined codes, packs the rest.
// Depends on i2cms_pkg and i2cms_cmd_if.
module i2cms_front (
  i2cms_cmd_if.sink              in_bus,
  input  logic                   push_ready,
  output i2cms_pkg::cmd_beat_t   push
);
  import i2cms_pkg::*;

  logic kind_ok;
  cmd_t cmd;

  // Decode the command and pick the byte and bit it needs
  always_comb begin
    kind_ok  = 1'b1;
    cmd.kind = kind_t'(in_bus.kind);
    cmd.data = 8'd0;
    cmd.ack  = 1'b0;
    unique case (in_bus.kind)
      KIND_START, KIND_STOP: begin
      end
      KIND_WRITE:    cmd.data = in_bus.tx_byte;
      KIND_READ:     cmd.data = in_bus.slave_bits;
      KIND_SEND_ACK: cmd.ack  = in_bus.ack_bit;
      KIND_RECV_ACK: cmd.ack  = in_bus.slave_ack;
      default: begin
        kind_ok  = 1'b0;
        cmd.kind = KIND_START;
      end
    endcase
  end

  // Undefined codes are taken and dropped
  assign in_bus.ready = push_ready;
  assign push.valid   = in_bus.valid && kind_ok;
  assign push.cmd     = cmd;

endmodule

// File: rtl/i2cms_fifo.sv
// Short command queue between front and back sequencer.
// Depends on i2cms_pkg.
module i2cms_fifo #(
  parameter int unsigned DEPTH = i2cms_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  i2cms_pkg::cmd_beat_t push,
  output logic                 push_ready,
  output i2cms_pkg::cmd_beat_t pop,
  input  logic                 pop_ready
);
  import i2cms_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop.valid  = (count_r != '0);
  assign pop.cmd    = mem_r[rd_ptr_r];
  assign do_push    = push.valid && push_ready;
  assign do_pop     = pop.valid && pop_ready;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage write
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.cmd;
    end
  end

endmodule

// File: rtl/i2cms_back.sv
// Back sequencer: steps through the pin phases of each command, paces them
// by the half-period register and holds the bus levels. Depends on i2cms_pkg.
module i2cms_back (
  input  logic                 clk,
  input  logic                 rst_n,
  i2cms_cfg_if.sink            cfg_bus,
  input  i2cms_pkg::cmd_beat_t pop,
  output logic                 pop_ready,
  i2cms_phase_if.source        out_bus
);
  import i2cms_pkg::*;

  logic [15:0] half_r;
  logic [15:0] timer_r, timer_nxt;
  logic        busy_r, busy_nxt;
  cmd_t        cmd_r, cmd_nxt;
  logic [1:0]  sub_r, sub_nxt;
  logic [2:0]  bit_r, bit_nxt;
  logic        scl_r, scl_nxt;
  logic        sda_r, sda_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        out_scl_r, out_sda_r, out_smp_r, out_ack_r, out_last_r;
  logic [7:0]  out_data_r;

  // Phase generator results
  logic        ph_scl, ph_sda, ph_smp, ph_last, ph_ack;
  logic [7:0]  ph_data;
  logic        cur_bit;
  logic        fire, load;

  assign cfg_bus.ready = 1'b1;

  // Pin levels for the current phase of the active command
  always_comb begin
    cur_bit = cmd_r.data[3'd7 - bit_r];
    ph_scl  = scl_r;
    ph_sda  = sda_r;
    ph_smp  = 1'b0;
    ph_last = 1'b0;
    ph_data = 8'd0;
    ph_ack  = 1'b0;
    unique case (cmd_r.kind)
      KIND_START: begin
        ph_sda  = (sub_r == 2'd0) || (sub_r == 2'd1);
        ph_scl  = (sub_r == 2'd0) ? scl_r : (sub_r != 2'd3);
        ph_last = (sub_r == 2'd3);
      end
      KIND_STOP: begin
        ph_sda  = (sub_r == 2'd2) || (sub_r == 2'd3);
        ph_scl  = (sub_r == 2'd0) ? scl_r : 1'b1;
        ph_last = (sub_r == 2'd2);
      end
      KIND_WRITE: begin
        ph_sda  = cur_bit;
        ph_scl  = (sub_r == 2'd0) ? scl_r : (sub_r == 2'd1);
        ph_last = (sub_r == 2'd2) && (bit_r == 3'd7);
      end
      KIND_READ: begin
        ph_sda  = sda_r;
        ph_scl  = (sub_r != 2'd2);
        ph_smp  = (sub_r == 2'd0);
        ph_last = (sub_r == 2'd2) && (bit_r == 3'd7);
        ph_data = (ph_last && sda_r) ? cmd_r.data : 8'd0;
      end
      KIND_SEND_ACK: begin
        ph_sda  = cmd_r.ack;
        ph_scl  = (sub_r == 2'd0) ? scl_r : (sub_r == 2'd1);
        ph_last = (sub_r == 2'd2);
      end
      KIND_RECV_ACK: begin
        // SDA is released before the sample, so the ack is the slave's level
        ph_sda  = 1'b1;
        ph_scl  = (sub_r == 2'd0) ? scl_r : (sub_r != 2'd3);
        ph_smp  = (sub_r == 2'd1);
        ph_last = (sub_r == 2'd3);
        ph_ack  = ph_last && cmd_r.ack;
      end
      default: begin
        ph_last = 1'b1;
      end
    endcase
  end

  // Emit a phase when the hold has run out and the output slot is free
  assign fire      = busy_r && (timer_r == 16'd0) && (!out_valid_r || out_bus.ready);
  assign load      = !busy_r || (fire && ph_last);
  assign pop_ready = load;

  // Sequencer next state
  always_comb begin
    busy_nxt      = busy_r;
    cmd_nxt       = cmd_r;
    sub_nxt       = sub_r;
    bit_nxt       = bit_r;
    scl_nxt       = scl_r;
    sda_nxt       = sda_r;
    timer_nxt     = (timer_r != 16'd0) ? timer_r - 16'd1 : timer_r;
    out_valid_nxt = out_valid_r && !out_bus.ready;
    if (fire) begin
      out_valid_nxt = 1'b1;
      scl_nxt       = ph_scl;
      sda_nxt       = ph_sda;
      timer_nxt     = (half_r == 16'd0) ? 16'd0 : half_r - 16'd1;
      if ((cmd_r.kind == KIND_WRITE) || (cmd_r.kind == KIND_READ) ||
          (cmd_r.kind == KIND_SEND_ACK)) begin
        if (sub_r == 2'd2) begin
          sub_nxt = 2'd0;
          bit_nxt = bit_r + 3'd1;
        end else begin
          sub_nxt = sub_r + 2'd1;
        end
      end else begin
        sub_nxt = sub_r + 2'd1;
      end
    end
    if (load) begin
      busy_nxt = pop.valid;
      cmd_nxt  = pop.cmd;
      sub_nxt  = 2'd0;
      bit_nxt  = 3'd0;
    end
  end

  // Control state and bus levels
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r      <= HALF_PERIOD_RESET;
      timer_r     <= 16'd0;
      busy_r      <= 1'b0;
      sub_r       <= 2'd0;
      bit_r       <= 3'd0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_bus.valid) begin
        half_r <= cfg_bus.data;
      end
      timer_r     <= timer_nxt;
      busy_r      <= busy_nxt;
      sub_r       <= sub_nxt;
      bit_r       <= bit_nxt;
      scl_r       <= scl_nxt;
      sda_r       <= sda_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    if (fire) begin
      out_scl_r  <= ph_scl;
      out_sda_r  <= ph_sda;
      out_smp_r  <= ph_smp;
      out_data_r <= ph_data;
      out_ack_r  <= ph_ack;
      out_last_r <= ph_last;
    end
  end

  assign out_bus.valid     = out_valid_r;
  assign out_bus.scl_level = out_scl_r;
  assign out_bus.sda_level = out_sda_r;
  assign out_bus.sampled   = out_smp_r;
  assign out_bus.rx_data   = out_data_r;
  assign out_bus.rx_ack    = out_ack_r;
  assign out_bus.last      = out_last_r;

endmodule

// File: rtl/i2c_master_bit_sequencer_top.sv
// I2C master bit sequencer, top level: front, command queue, back sequencer.
// Depends on i2cms_pkg, the channel interfaces and the three submodules.
//
// Each command beat (start, stop, write byte, read byte, send ack, receive
// ack) becomes a run of 3 to 24 phase beats on out_bus, one SCL/SDA level
// pair each, last set on the final one. The back sequencer's hold timer spaces
// phase beats by the half-period register (reset 500; a value of 0 spaces
// them like a value of 1), so a command lasts longer with more phases, a larger
// half-period or stalls on out_bus. A short queue lets new commands be taken
// while a run is in progress; undefined codes 6 and 7 are accepted and produce
// no phases. Write the half-period only while idle.
module i2c_master_bit_sequencer_top #(
  parameter int unsigned QUEUE_DEPTH = i2cms_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  i2cms_cmd_if.sink     in_bus,
  i2cms_phase_if.source out_bus,
  i2cms_cfg_if.sink     cfg_bus
);
  import i2cms_pkg::*;

  cmd_beat_t push, pop;
  logic      push_ready, pop_ready;

  i2cms_front u_front (
    .in_bus     (in_bus),
    .push_ready (push_ready),
    .push       (push)
  );

  i2cms_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_ready  (pop_ready)
  );

  i2cms_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_bus   (cfg_bus),
    .pop       (pop),
    .pop_ready (pop_ready),
    .out_bus   (out_bus)
  );

endmodule
